// ----- sv/tepa_pkg.sv -----
// Package for the twisted Edwards point adder: field constants, payload types,
// sequencer states. No dependencies.
`default_nettype none
package tepa_pkg;
  localparam int LIMBS_PER_COORD = 4;
  localparam logic [255:0] FIELD_P =
    256'h30644e72e131a029b85045b68181585d2833e84879b97091_43e1f593f0000001;
  localparam logic [255:0] FIELD_PM2 =
    256'h30644e72e131a029b85045b68181585d2833e84879b97091_43e1f593efffffff;
  localparam logic [31:0] CURVE_A_RST = 32'd168700;
  localparam logic [31:0] CURVE_D_RST = 32'd168696;
  localparam logic CFG_IDX_A = 1'b0;
  localparam logic CFG_IDX_D = 1'b1;

  typedef struct packed {
    logic [3:0]  word_index;
    logic [63:0] word_value;
    logic        start_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_index;
    logic [63:0] result_value;
    logic        error;
    logic        last;
  } out_item_t;

  // field unit operations
  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_RED} fop_t;

  typedef struct packed {
    logic start;
    fop_t op;
  } fu_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_M1, S_M2, S_M3, S_M4, S_ADDN, S_M5, S_M6, S_DX, S_DY,
    S_CHK, S_INV, S_MX3, S_M7, S_SUBN, S_INVY, S_MY3, S_OUT
  } seq_state_t;
endpackage
`default_nettype wire

// ----- sv/twisted_edwards_point_add.sv -----
// Top level of the twisted Edwards point adder over the BN254 scalar field.
// Uses tepa_pkg and tepa_field_unit.
`default_nettype none
// A word with start_req clear is stored. A word with start_req set starts
// the addition: four reductions, nine modular multiplies and two inversions
// (each 256 squarings plus 127 multiplies for the set bits of p-2) all run
// through one shared field unit, which a multiply holds from issue to
// completion. When a denominator is zero the inversions are skipped. Then
// eight result transactions follow, one per cycle as the consumer takes
// them. in_ready is low from start until the last result.
module twisted_edwards_point_add import tepa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int NW = 4 * LIMBS_PER_COORD;
  logic [63:0]  opw_r [NW];
  logic [255:0] wr_r [8];
  logic [31:0]  ca_r, cd_r;
  seq_state_t   st_r, st_nxt;
  logic [1:0]   ci_r, ci_nxt;
  logic [8:0]   ib_r, ib_nxt;
  logic         isq_r, isq_nxt;
  logic         pend_r, pend_nxt;
  logic         err_r, err_nxt;
  logic [2:0]   oi_r, oi_nxt;
  fu_ctl_t      ctl;
  logic [255:0] opa, opb, res, inv_r, dx_r, dy_r, num_r, x1x2_r, y1y2_r;
  logic         fdone;
  logic [2:0]   wsel;
  logic         wen;
  logic [255:0] wval;

  tepa_field_unit u_fu (.clk, .rst_n, .ctl, .opa, .opb, .done(fdone), .res);

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r; ci_nxt = ci_r; ib_nxt = ib_r; isq_nxt = isq_r;
    pend_nxt = pend_r; err_nxt = err_r; oi_nxt = oi_r;
    ctl = '{start: 1'b0, op: OP_MUL};
    opa = '0; opb = '0; wen = 1'b0; wsel = 3'd0; wval = res;
    unique case (st_r)
      S_IDLE: if (in_valid && in_data.start_req) begin
        st_nxt = S_RED; ci_nxt = 2'd0; pend_nxt = 1'b0; err_nxt = 1'b0;
      end
      S_RED: begin
        opa = {opw_r[{ci_r, 2'd3}], opw_r[{ci_r, 2'd2}], opw_r[{ci_r, 2'd1}],
               opw_r[{ci_r, 2'd0}]};
        ctl = '{start: !pend_r, op: OP_RED};
        pend_nxt = 1'b1;
        if (fdone) begin
          wen = 1'b1; wsel = {1'b0, ci_r}; pend_nxt = 1'b0; ci_nxt = ci_r + 2'd1;
          if (ci_r == 2'd3) st_nxt = S_M1;
        end
      end
      S_INV, S_INVY: begin
        // square-and-multiply over the bits of p-2
        opa = inv_r; opb = isq_r ? (st_r == S_INV ? dx_r : dy_r) : inv_r;
        ctl = '{start: !pend_r, op: OP_MUL};
        pend_nxt = 1'b1;
        if (fdone) begin
          pend_nxt = 1'b0;
          if (!isq_r && FIELD_PM2[ib_r[7:0]]) isq_nxt = 1'b1;
          else begin
            isq_nxt = 1'b0;
            ib_nxt = ib_r - 9'd1;
            if (ib_r == 9'd0) st_nxt = (st_r == S_INV) ? S_MX3 : S_MY3;
          end
        end
      end
      S_CHK: begin
        if (dx_r == '0 || dy_r == '0) begin
          err_nxt = 1'b1; st_nxt = S_OUT; oi_nxt = 3'd0;
        end else begin
          st_nxt = S_INV; ib_nxt = 9'd255; isq_nxt = 1'b0;
        end
      end
      S_OUT: if (out_ready) begin
        oi_nxt = oi_r + 3'd1;
        if (oi_r == 3'd7) st_nxt = S_IDLE;
      end
      default: begin
        // single field operations in sequence
        unique case (st_r)
          S_M1:   begin opa = wr_r[0]; opb = wr_r[2]; end
          S_M2:   begin opa = wr_r[1]; opb = wr_r[3]; end
          S_M3:   begin opa = wr_r[0]; opb = wr_r[3]; end
          S_M4:   begin opa = wr_r[1]; opb = wr_r[2]; end
          S_ADDN: begin opa = wr_r[6]; opb = wr_r[7]; ctl.op = OP_ADD; end
          S_M5:   begin opa = x1x2_r; opb = y1y2_r; end
          S_M6:   begin opa = {224'd0, cd_r}; opb = wr_r[6]; end
          S_DX:   begin opa = 256'd1; opb = wr_r[6]; ctl.op = OP_ADD; end
          S_DY:   begin opa = 256'd1; opb = wr_r[6]; ctl.op = OP_SUB; end
          S_MX3:  begin opa = num_r; opb = inv_r; end
          S_M7:   begin opa = {224'd0, ca_r}; opb = x1x2_r; end
          S_SUBN: begin opa = y1y2_r; opb = wr_r[7]; ctl.op = OP_SUB; end
          default: begin opa = num_r; opb = inv_r; end
        endcase
        ctl.start = !pend_r;
        pend_nxt = 1'b1;
        if (fdone) begin
          pend_nxt = 1'b0;
          unique case (st_r)
            S_M1:   st_nxt = S_M2;
            S_M2:   st_nxt = S_M3;
            S_M3:   begin wen = 1'b1; wsel = 3'd6; st_nxt = S_M4; end
            S_M4:   begin wen = 1'b1; wsel = 3'd7; st_nxt = S_ADDN; end
            S_ADDN: st_nxt = S_M5;
            S_M5:   begin wen = 1'b1; wsel = 3'd6; st_nxt = S_M6; end
            S_M6:   begin wen = 1'b1; wsel = 3'd6; st_nxt = S_DX; end
            S_DX:   st_nxt = S_DY;
            S_DY:   st_nxt = S_CHK;
            S_MX3:  begin wen = 1'b1; wsel = 3'd4; st_nxt = S_M7; end
            S_M7:   begin wen = 1'b1; wsel = 3'd7; st_nxt = S_SUBN; end
            S_SUBN: begin st_nxt = S_INVY; ib_nxt = 9'd255; isq_nxt = 1'b0; end
            default: begin wen = 1'b1; wsel = 3'd5; st_nxt = S_OUT; oi_nxt = 3'd0; end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pend_r <= 1'b0; ca_r <= CURVE_A_RST; cd_r <= CURVE_D_RST;
      for (int i = 0; i < 8; i++) wr_r[i] <= '0;
    end else begin
      st_r <= st_nxt; pend_r <= pend_nxt;
      if (cfg_valid && cfg_index == CFG_IDX_A) ca_r <= cfg_data[31:0];
      if (cfg_valid && cfg_index == CFG_IDX_D) cd_r <= cfg_data[31:0];
      if (wen) wr_r[wsel] <= wval;
    end
    ci_r <= ci_nxt; ib_r <= ib_nxt; isq_r <= isq_nxt; err_r <= err_nxt; oi_r <= oi_nxt;
    if (in_valid && in_ready) opw_r[in_data.word_index] <= in_data.word_value;
    if (fdone && st_r == S_M1) x1x2_r <= res;
    if (fdone && st_r == S_M2) y1y2_r <= res;
    if (fdone && (st_r == S_ADDN || st_r == S_SUBN)) num_r <= res;
    if (fdone && st_r == S_DX) dx_r <= res;
    if (fdone && st_r == S_DY) dy_r <= res;
    if (st_r == S_CHK || (st_r == S_SUBN && fdone)) inv_r <= 256'd1;
    else if (fdone && (st_r == S_INV || st_r == S_INVY)) inv_r <= res;
  end

  logic [255:0] oc;
  assign oc = oi_r[2] ? wr_r[5] : wr_r[4];
  assign out_valid = (st_r == S_OUT);
  assign out_data.result_index = oi_r;
  assign out_data.result_value = err_r ? 64'd0 : oc[{oi_r[1:0], 6'd0} +: 64];
  assign out_data.error = err_r;
  assign out_data.last = (oi_r == 3'd7);

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accepting while emitting");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.result_value == 64'd0)
    else $error("error word not zero");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready)
    else $error("not idle after last");
`endif
endmodule
`default_nettype wire

// ----- sv/tepa_field_unit.sv -----
// Shared modular arithmetic unit: multiply (double-and-add, a double then
// a conditional add per bit), add, subtract, full reduction. Uses tepa_pkg.
`default_nettype none
module tepa_field_unit import tepa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fu_ctl_t      ctl,
  input  wire logic [255:0] opa,
  input  wire logic [255:0] opb,
  output logic              done,
  output logic [255:0]      res
);
  logic         busy_r, busy_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic [255:0] acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt;
  fop_t         op_r, op_nxt;
  logic         done_r, done_nxt;
  logic [256:0] sum;
  logic [256:0] dif;
  logic [255:0] addend_a, addend_b, summod;

  always_comb begin
    addend_a = acc_r;
    addend_b = acc_r;
    if (op_r == OP_ADD || op_r == OP_SUB || op_r == OP_RED) begin
      addend_a = a_r;
      addend_b = b_r;
    end else if (cnt_r[0]) begin
      addend_b = a_r;
    end
    sum = {1'b0, addend_a} + {1'b0, addend_b};
    dif = {1'b0, addend_a} - {1'b0, addend_b};
    summod = (sum >= {1'b0, FIELD_P}) ? 256'(sum - {1'b0, FIELD_P}) : sum[255:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    op_nxt   = op_r;
    done_nxt = 1'b0;
    if (!busy_r) begin
      if (ctl.start) begin
        busy_nxt = 1'b1;
        op_nxt   = ctl.op;
        a_nxt    = opa;
        b_nxt    = opb;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        if (ctl.op == OP_RED) b_nxt = FIELD_P;
      end
    end else begin
      unique case (op_r)
        OP_ADD: begin
          acc_nxt = summod; busy_nxt = 1'b0; done_nxt = 1'b1;
        end
        OP_SUB: begin
          acc_nxt = dif[256] ? 256'(dif + {1'b0, FIELD_P}) : dif[255:0];
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end
        OP_RED: begin
          // one conditional subtract per cycle, eight passes
          if (!dif[256]) a_nxt = dif[255:0];
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_r == 8'd7) begin
            acc_nxt = dif[256] ? a_r : dif[255:0];
            busy_nxt = 1'b0; done_nxt = 1'b1;
          end
        end
        default: begin
          // even count: double; odd count: add a if bit set, shift b
          if (!cnt_r[0]) begin
            acc_nxt = summod;
          end else begin
            if (b_r[255]) acc_nxt = summod;
            b_nxt = {b_r[254:0], 1'b0};
          end
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_r == 8'd255 && cnt_r[0]) begin
            busy_nxt = 1'b0; done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // multiply needs 512 steps: use a ninth count bit via wrap flag
  logic wrap_r, wrap_nxt;
  always_comb begin
    wrap_nxt = wrap_r;
    if (!busy_r) wrap_nxt = 1'b0;
    else if (op_r == OP_MUL && cnt_r == 8'd255) wrap_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      wrap_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt && !(op_r == OP_MUL && busy_r && !wrap_r && cnt_r == 8'd255)
                || (op_r == OP_MUL && busy_r && !wrap_r && cnt_r == 8'd255);
      done_r <= done_nxt && !(op_r == OP_MUL && !wrap_r);
      wrap_r <= wrap_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    op_r  <= op_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_r)
    else $error("done while busy");
  a_res_lt_p: assert property (@(posedge clk) disable iff (!rst_n) done |-> res < FIELD_P)
    else $error("result not reduced");
  a_start_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !done_nxt |=> $stable(op_r))
    else $error("op changed mid-operation");
`endif
endmodule
`default_nettype wire

// ----- bench/twisted_edwards_point_add_tb.sv -----
// Testbench for twisted_edwards_point_add: loads point limbs, runs additions
// over the BN254 scalar field and checks every sum limb against its own predictor.
// Depends on tepa_pkg and the twisted_edwards_point_add RTL.
module twisted_edwards_point_add_tb;
  import tepa_pkg::*;

  localparam longint CYCLE_LIMIT = 8000000;
  localparam int     HOLD_LEN = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  twisted_edwards_point_add uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0] limb_store [16];
  logic [31:0] coef_a;
  logic [31:0] coef_d;
  out_item_t   sum_queue [$];
  bit          failed;
  longint      cycle_count;
  bit          hold_req;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [255:0] fmul(logic [255:0] x, logic [255:0] y);
    logic [511:0] prod;
    prod = {256'd0, x} * {256'd0, y};
    return 256'(prod % {256'd0, FIELD_P});
  endfunction

  function automatic logic [255:0] finv(logic [255:0] x);
    logic [255:0] acc;
    acc = 256'd1;
    for (int i = 255; i >= 0; i--) begin
      acc = fmul(acc, acc);
      if (FIELD_PM2[i]) acc = fmul(acc, x);
    end
    return acc;
  endfunction

  function automatic logic [255:0] fadd(logic [255:0] x, logic [255:0] y);
    logic [256:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, FIELD_P}) s = s - {1'b0, FIELD_P};
    return s[255:0];
  endfunction

  function automatic logic [255:0] fsub(logic [255:0] x, logic [255:0] y);
    return (x >= y) ? x - y : x + FIELD_P - y;
  endfunction

  // Compute the Edwards sum from the stored limbs and queue eight result limbs.
  task automatic predict_point_sum();
    logic [255:0] crd [4];
    logic [255:0] x1x2, y1y2, num_x, num_y, dtau, den_x, den_y, x3, y3;
    logic [511:0] both;
    bit           bad;
    out_item_t    r;
    for (int c = 0; c < 4; c++) begin
      crd[c] = {limb_store[4*c+3], limb_store[4*c+2], limb_store[4*c+1], limb_store[4*c]};
      crd[c] = crd[c] % FIELD_P;
    end
    x1x2  = fmul(crd[0], crd[2]);
    y1y2  = fmul(crd[1], crd[3]);
    num_x = fadd(fmul(crd[0], crd[3]), fmul(crd[1], crd[2]));
    dtau  = fmul({224'd0, coef_d}, fmul(x1x2, y1y2));
    den_x = fadd(256'd1, dtau);
    den_y = fsub(256'd1, dtau);
    bad   = (den_x == 0) || (den_y == 0);
    x3 = 0;
    y3 = 0;
    if (!bad) begin
      x3    = fmul(num_x, finv(den_x));
      num_y = fsub(y1y2, fmul({224'd0, coef_a}, x1x2));
      y3    = fmul(num_y, finv(den_y));
    end
    both = {y3, x3};
    for (int k = 0; k < 8; k++) begin
      r.result_index = 3'(k);
      r.result_value = both[64*k +: 64];
      r.error        = bad;
      r.last         = (k == 7);
      sum_queue.push_back(r);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = sum_queue.pop_front();
        if (out_data.result_index !== want.result_index) begin
          $display("%0t: result_index expected %0d actual %0d", $time,
                   want.result_index, out_data.result_index);
          failed = 1'b1;
        end
        if (out_data.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, out_data.result_value);
          failed = 1'b1;
        end
        if (out_data.error !== want.error) begin
          $display("%0t: error expected %b actual %b", $time, want.error, out_data.error);
          failed = 1'b1;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver: random stalls; once requested, hold off until hold_cnt reaches
  // HOLD_LEN, counting only while a result is waiting
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      if (out_valid) begin
        if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end
    end else begin
      out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("twisted_edwards_point_add_tb failed");
      $finish;
    end
  end

  task automatic send_word(logic [3:0] idx, logic [63:0] val, logic go);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{word_index: idx, word_value: val, start_req: go};
    do @(posedge clk); while (!in_ready);
    limb_store[idx] = val;
    if (go) predict_point_sum();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    // words without start leave no trace; let the block settle
    repeat (40) @(posedge clk);
  endtask

  task automatic write_coef(logic idx, logic [63:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IDX_A) coef_a = val[31:0];
    else coef_d = val[31:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_limb();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // x1 all ones (above p), y1 zero, mixed others, default curve
  task automatic test_reduction_and_extremes();
    for (int i = 0; i < 16; i++) begin
      logic [63:0] v;
      v = (i < 4) ? '1 : (i < 8) ? 64'd0 :
          (i < 12) ? {$urandom, $urandom} : FIELD_P[64*(i-12) +: 64];
      if (i == 12) v = v + 64'd3;
      send_word(4'(i), v, i == 15);
    end
  endtask

  // d = 1 and x1 = p-1 with the other coordinates one: 1 + d*tau vanishes
  task automatic test_zero_denominator();
    logic [255:0] pm1;
    pm1 = FIELD_P - 256'd1;
    write_coef(CFG_IDX_D, 64'd1);
    for (int i = 0; i < 16; i++)
      send_word(4'(i), (i < 4) ? pm1[64*i +: 64] : ((i % 4) == 0) ? 64'd1 : 64'd0, i == 15);
  endtask

  task automatic test_coef_extremes();
    write_coef(CFG_IDX_A, 64'd0);
    write_coef(CFG_IDX_D, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 16; i++) send_word(4'(i), {$urandom, $urandom}, i == 15);
  endtask

  task automatic test_random_points();
    int order [16];
    for (int s = 0; s < 3; s++) begin
      if (s == 1) begin
        write_coef(CFG_IDX_A, 64'hffff_ffff_ffff_ffff);
        write_coef(CFG_IDX_D, 64'd0);
      end
      if (s == 2) begin
        write_coef(CFG_IDX_A, {$urandom, $urandom});
        write_coef(CFG_IDX_D, {$urandom, $urandom});
      end
      // noise: stray word writes, no start
      repeat ($urandom_range(8, 16)) send_word(4'($urandom_range(0, 15)), rand_limb(), 1'b0);
      for (int i = 0; i < 16; i++) order[i] = i;
      order.shuffle();
      for (int i = 0; i < 16; i++) send_word(4'(order[i]), rand_limb(), i == 15);
      // hold results back while the next words keep pressing on the input
      if (s == 0) hold_req = 1'b1;
      repeat (6) send_word(4'($urandom_range(0, 15)), rand_limb(), 1'b0);
    end
    drain();
    repeat (10) send_word(4'($urandom_range(0, 15)), rand_limb(), 1'b0);
  endtask

  initial begin
    failed = 1'b0;
    cycle_count = 0;
    hold_req = 1'b0;
    coef_a = CURVE_A_RST;
    coef_d = CURVE_D_RST;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_A;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reduction_and_extremes();
    test_zero_denominator();
    test_coef_extremes();
    test_random_points();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("twisted_edwards_point_add_tb passed");
    else $display("twisted_edwards_point_add_tb failed");
    $finish;
  end
endmodule
